// ===== hdl/cpbq_pkg.sv =====
// Package for the CIGAR point base quality histogram unit.
// Holds payload structs, register and code constants and a saturating adder.
// No dependencies; every other file in this folder imports it.
package cpbq_pkg;

   localparam int QUAL_BINS_DEFAULT = 128;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [1:0] MODE_HEADER = 2'd0;
   localparam logic [1:0] MODE_CIGAR = 2'd1;
   localparam logic [1:0] MODE_BASE = 2'd2;
   localparam logic [1:0] MODE_READOUT = 2'd3;

   localparam logic [3:0] OP_M = 4'd0;
   localparam logic [3:0] OP_I = 4'd1;
   localparam logic [3:0] OP_D = 4'd2;
   localparam logic [3:0] OP_N = 4'd3;
   localparam logic [3:0] OP_S = 4'd4;

   localparam logic [3:0] BASE_A = 4'd1;
   localparam logic [3:0] BASE_C = 4'd2;
   localparam logic [3:0] BASE_G = 4'd4;
   localparam logic [3:0] BASE_T = 4'd8;

   typedef enum logic [1:0] {
      CSR_TARGET_POSITION = 2'd0,
      CSR_REFERENCE_LENGTH = 2'd1,
      CSR_CAP_BY_MAPQ = 2'd2,
      CSR_SKIP_DUPLICATES = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [30:0] read_pos;
      logic [7:0] map_quality;
      logic reverse_strand;
      logic duplicate;
      logic [3:0] cigar_op;
      logic [27:0] cigar_len;
      logic [3:0] base_code;
      logic [7:0] base_quality;
      logic [9:0] bin_index;
   } req_type;

   typedef struct packed {
      logic [31:0] bin_count;
      logic [9:0] bin_echo;
   } rsp_type;

   typedef struct packed {
      logic [30:0] target_position;
      logic [30:0] reference_length;
      logic cap_by_mapq;
      logic skip_duplicates;
   } cfg_type;

   function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

endpackage

// ===== hdl/cpbq_front.sv =====
// Front end: accepts items, walks the CIGAR ops and classifies bases.
// Emits histogram increment and readout transactions to the queue.
// Depends on cpbq_pkg.
module cpbq_front #(
   parameter int QUAL_BINS = cpbq_pkg::QUAL_BINS_DEFAULT,
   parameter int ADDR_W = 10,
   parameter int IDX_W = 10
) (
   input logic clock,
   input logic reset,
   input logic accept,
   input cpbq_pkg::req_type req,
   input cpbq_pkg::cfg_type cfg,
   output logic push,
   output logic push_read,
   output logic [IDX_W-1:0] push_idx
);
   import cpbq_pkg::*;

   logic [31:0] ref_cursor_ff, ref_cursor_in;
   logic [31:0] query_cursor_ff, query_cursor_in;
   logic [31:0] target_offset_ff, target_offset_in;
   logic target_found_ff, target_found_in;
   logic [31:0] base_counter_ff, base_counter_in;
   logic [7:0] read_mapq_ff, read_mapq_in;
   logic read_reverse_ff, read_reverse_in;
   logic read_skipped_ff, read_skipped_in;

   logic [32:0] m_sum;
   logic m_over;
   logic ref_below_end;
   logic [31:0] m_run;
   logic [31:0] m_ref_next;
   logic m_hit;
   logic [31:0] tp_ext;
   logic [31:0] rl_ext;
   logic [31:0] len_ext;

   logic base_hit;
   logic base_ok;
   logic [1:0] base_sel;
   logic [7:0] qual_c;
   logic [ADDR_W-1:0] bin_addr;

   always_comb begin
      tp_ext = {1'b0, cfg.target_position};
      rl_ext = {1'b0, cfg.reference_length};
      len_ext = {4'd0, req.cigar_len};
      m_sum = {1'b0, ref_cursor_ff} + {1'b0, len_ext};
      m_over = m_sum > {1'b0, rl_ext};
      ref_below_end = rl_ext > ref_cursor_ff;
      if (m_over) begin
         m_run = ref_below_end ? (rl_ext - ref_cursor_ff) : 32'd0;
         m_ref_next = ref_below_end ? rl_ext : ref_cursor_ff;
         m_hit = (ref_cursor_ff <= tp_ext) && ref_below_end && (tp_ext < rl_ext);
      end else begin
         m_run = len_ext;
         m_ref_next = m_sum[31:0];
         m_hit = (ref_cursor_ff <= tp_ext) && ({1'b0, tp_ext} < m_sum);
      end
   end

   always_comb begin
      base_hit = !read_skipped_ff && target_found_ff && (base_counter_ff == target_offset_ff);
      base_ok = 1'b1;
      base_sel = 2'd0;
      unique case (req.base_code)
         BASE_A: base_sel = 2'd0;
         BASE_C: base_sel = 2'd1;
         BASE_G: base_sel = 2'd2;
         BASE_T: base_sel = 2'd3;
         default: base_ok = 1'b0;
      endcase
      if ({1'b0, req.base_quality} >= 9'(QUAL_BINS)) begin
         base_ok = 1'b0;
      end
      qual_c = req.base_quality;
      if (cfg.cap_by_mapq && (read_mapq_ff < req.base_quality)) begin
         qual_c = read_mapq_ff;
      end
      bin_addr = ADDR_W'({read_reverse_ff, base_sel}) * ADDR_W'(QUAL_BINS) + ADDR_W'(qual_c);
   end

   always_comb begin
      ref_cursor_in = ref_cursor_ff;
      query_cursor_in = query_cursor_ff;
      target_offset_in = target_offset_ff;
      target_found_in = target_found_ff;
      base_counter_in = base_counter_ff;
      read_mapq_in = read_mapq_ff;
      read_reverse_in = read_reverse_ff;
      read_skipped_in = read_skipped_ff;
      push = 1'b0;
      push_read = 1'b0;
      push_idx = IDX_W'(bin_addr);
      if (accept) begin
         unique case (req.mode)
            MODE_HEADER: begin
               ref_cursor_in = {1'b0, req.read_pos};
               read_mapq_in = req.map_quality;
               read_reverse_in = req.reverse_strand;
               read_skipped_in = cfg.skip_duplicates && req.duplicate;
               query_cursor_in = 32'd0;
               target_offset_in = 32'd0;
               target_found_in = 1'b0;
               base_counter_in = 32'd0;
            end
            MODE_CIGAR: begin
               if (!read_skipped_ff && !target_found_ff) begin
                  unique case (req.cigar_op)
                     OP_M: begin
                        if (m_hit) begin
                           target_offset_in = sat_add32(query_cursor_ff,
                                                        tp_ext - ref_cursor_ff);
                           target_found_in = 1'b1;
                        end else begin
                           ref_cursor_in = m_ref_next;
                           query_cursor_in = sat_add32(query_cursor_ff, m_run);
                        end
                     end
                     OP_I, OP_S: begin
                        query_cursor_in = sat_add32(query_cursor_ff, len_ext);
                     end
                     OP_D, OP_N: begin
                        ref_cursor_in = sat_add32(ref_cursor_ff, len_ext);
                     end
                     default: begin
                     end
                  endcase
               end
            end
            MODE_BASE: begin
               base_counter_in = sat_add32(base_counter_ff, 32'd1);
               push = base_hit && base_ok;
            end
            MODE_READOUT: begin
               push = 1'b1;
               push_read = 1'b1;
               push_idx = IDX_W'(req.bin_index);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_cursor_ff <= 32'd0;
         query_cursor_ff <= 32'd0;
         target_offset_ff <= 32'd0;
         target_found_ff <= 1'b0;
         base_counter_ff <= 32'd0;
         read_mapq_ff <= 8'd0;
         read_reverse_ff <= 1'b0;
         read_skipped_ff <= 1'b1;
      end else begin
         ref_cursor_ff <= ref_cursor_in;
         query_cursor_ff <= query_cursor_in;
         target_offset_ff <= target_offset_in;
         target_found_ff <= target_found_in;
         base_counter_ff <= base_counter_in;
         read_mapq_ff <= read_mapq_in;
         read_reverse_ff <= read_reverse_in;
         read_skipped_ff <= read_skipped_in;
      end
   end

endmodule

// ===== hdl/cpbq_queue.sv =====
// Short transaction queue between the front end and the histogram back end.
// Each entry holds a readout flag and a bin index. Depends on cpbq_pkg.
module cpbq_queue #(
   parameter int IDX_W = 10
) (
   input logic clock,
   input logic reset,
   input logic push,
   input logic push_read,
   input logic [IDX_W-1:0] push_idx,
   input logic pop,
   output logic empty,
   output logic full,
   output logic pop_read,
   output logic [IDX_W-1:0] pop_idx
);
   import cpbq_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   logic [IDX_W:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0] count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign pop_read = entry_ff[rd_ptr_ff][IDX_W];
   assign pop_idx = entry_ff[rd_ptr_ff][IDX_W-1:0];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= {push_read, push_idx};
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== hdl/cpbq_back.sv =====
// Back end: owns the histogram memory, clears it after reset, applies
// increments by read-modify-write and answers readouts. Depends on cpbq_pkg.
module cpbq_back #(
   parameter int QUAL_BINS = cpbq_pkg::QUAL_BINS_DEFAULT,
   parameter int ADDR_W = 10,
   parameter int IDX_W = 10
) (
   input logic clock,
   input logic reset,
   input logic empty,
   input logic pop_read,
   input logic [IDX_W-1:0] pop_idx,
   output logic pop,
   output logic clearing,
   output logic rsp_strobe,
   output cpbq_pkg::rsp_type rsp_payload
);
   import cpbq_pkg::*;

   localparam int HIST_BINS = 8 * QUAL_BINS;

   logic [31:0] hist_mem [HIST_BINS];

   logic clear_ff;
   logic [ADDR_W-1:0] clear_addr_ff;
   logic s1_valid_ff;
   logic s1_read_ff;
   logic [IDX_W-1:0] s1_idx_ff;
   logic [31:0] rd_data_ff;
   logic fwd_valid_ff;
   logic [ADDR_W-1:0] fwd_addr_ff;
   logic [31:0] fwd_data_ff;
   logic rsp_strobe_ff;
   rsp_type rsp_payload_ff;

   logic [ADDR_W-1:0] s1_addr;
   logic [31:0] cur_value;
   logic [31:0] inc_value;
   logic s1_inc;
   logic s1_in_range;

   assign pop = !clear_ff && !empty;
   assign clearing = clear_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_payload = rsp_payload_ff;

   always_comb begin
      s1_addr = ADDR_W'(s1_idx_ff);
      cur_value = (fwd_valid_ff && (fwd_addr_ff == s1_addr)) ? fwd_data_ff : rd_data_ff;
      inc_value = cur_value + 32'd1;
      s1_inc = s1_valid_ff && !s1_read_ff;
      s1_in_range = {1'b0, s1_idx_ff} < (IDX_W+1)'(HIST_BINS);
   end

   always_ff @(posedge clock) begin
      if (clear_ff) begin
         hist_mem[clear_addr_ff] <= 32'd0;
      end else if (s1_inc) begin
         hist_mem[s1_addr] <= inc_value;
      end
      if (pop) begin
         rd_data_ff <= hist_mem[ADDR_W'(pop_idx)];
      end
      s1_read_ff <= pop_read;
      s1_idx_ff <= pop_idx;
      fwd_addr_ff <= s1_addr;
      fwd_data_ff <= inc_value;
      rsp_payload_ff.bin_count <= s1_in_range ? cur_value : 32'd0;
      rsp_payload_ff.bin_echo <= 10'(s1_idx_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff <= 1'b1;
         clear_addr_ff <= '0;
         s1_valid_ff <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (clear_ff) begin
            clear_addr_ff <= clear_addr_ff + ADDR_W'(1);
            if (clear_addr_ff == ADDR_W'(HIST_BINS - 1)) begin
               clear_ff <= 1'b0;
            end
         end
         s1_valid_ff <= pop;
         fwd_valid_ff <= s1_inc;
         rsp_strobe_ff <= s1_valid_ff && s1_read_ff;
      end
   end

endmodule

// ===== hdl/cigar_point_base_quality_histogram_unit.sv =====
// Top level of the CIGAR point base quality histogram unit.
// Holds the configuration registers and joins front end, queue and back end.
// Depends on cpbq_pkg, cpbq_front, cpbq_queue and cpbq_back.
//
// Usage: items enter on req_payload and are taken at a clock edge where
// start is high and busy is low. Header, CIGAR op and base items update the
// read walk in the front end; a counted base and every readout become a
// transaction in a four-entry queue that the histogram back end drains.
// A readout item gives one result on rsp_payload, marked by rsp_strobe for
// one cycle, once it has passed the queue entry and the back end's stage-one
// and result registers; other items give none. Results leave in the order
// their readouts were taken. Throughput is one item per cycle while busy
// is low; the back end's pipelined read-modify-write of the histogram
// memory, with forwarding between back-to-back increments, sets that
// figure. Reset clears the read state and starts a clearing pass that
// zeroes all 8*QUAL_BINS bins (1024 by default), one bin per cycle; busy
// stays high until it ends. The configuration port is always ready, and
// registers take their reset values. The receiver cannot stall results.
module cigar_point_base_quality_histogram_unit #(
   parameter int QUAL_BINS = cpbq_pkg::QUAL_BINS_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input cpbq_pkg::req_type req_payload,
   output logic rsp_strobe,
   output cpbq_pkg::rsp_type rsp_payload,
   input logic csr_valid,
   output logic csr_ready,
   input logic [1:0] csr_index,
   input logic [31:0] csr_data
);
   import cpbq_pkg::*;

   localparam int ADDR_W = $clog2(8 * QUAL_BINS);
   localparam int IDX_W = (ADDR_W > 10) ? ADDR_W : 10;

   cfg_type cfg_ff;
   logic accept;
   logic push;
   logic push_read;
   logic [IDX_W-1:0] push_idx;
   logic pop;
   logic empty;
   logic full;
   logic pop_read;
   logic [IDX_W-1:0] pop_idx;
   logic clearing;

   assign csr_ready = 1'b1;
   assign busy = clearing || full;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_position <= 31'd0;
         cfg_ff.reference_length <= 31'h7FFF_FFFF;
         cfg_ff.cap_by_mapq <= 1'b0;
         cfg_ff.skip_duplicates <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_TARGET_POSITION: cfg_ff.target_position <= csr_data[30:0];
            CSR_REFERENCE_LENGTH: cfg_ff.reference_length <= csr_data[30:0];
            CSR_CAP_BY_MAPQ: cfg_ff.cap_by_mapq <= csr_data[0];
            CSR_SKIP_DUPLICATES: cfg_ff.skip_duplicates <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   cpbq_front #(
      .QUAL_BINS(QUAL_BINS),
      .ADDR_W(ADDR_W),
      .IDX_W(IDX_W)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .req(req_payload),
      .cfg(cfg_ff),
      .push(push),
      .push_read(push_read),
      .push_idx(push_idx)
   );

   cpbq_queue #(
      .IDX_W(IDX_W)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_read(push_read),
      .push_idx(push_idx),
      .pop(pop),
      .empty(empty),
      .full(full),
      .pop_read(pop_read),
      .pop_idx(pop_idx)
   );

   cpbq_back #(
      .QUAL_BINS(QUAL_BINS),
      .ADDR_W(ADDR_W),
      .IDX_W(IDX_W)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .empty(empty),
      .pop_read(pop_read),
      .pop_idx(pop_idx),
      .pop(pop),
      .clearing(clearing),
      .rsp_strobe(rsp_strobe),
      .rsp_payload(rsp_payload)
   );

endmodule

// ===== tb/cpbq_histogram_checker.sv =====
`timescale 1ns / 1ps
// Checker for the CIGAR point base quality histogram unit: it watches the request,
// result and register channels, predicts every readout and compares the results.
// Depends on cpbq_pkg for the payload structs, register indexes and code constants.
module cpbq_histogram_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input cpbq_pkg::req_type req_payload,
   input logic rsp_strobe,
   input cpbq_pkg::rsp_type rsp_payload,
   input logic csr_valid,
   input logic csr_ready,
   input logic [1:0] csr_index,
   input logic [31:0] csr_data,
   output int readouts_pending,
   output int mismatch_count
);
   import cpbq_pkg::*;

   localparam int QB = QUAL_BINS_DEFAULT;
   localparam int BINS = 8 * QB;
   localparam int MAX_REPORTS = 10;

   logic [30:0] cfg_target;
   logic [30:0] cfg_ref_len;
   logic cfg_cap;
   logic cfg_skip;

   logic [31:0] bin_counts [BINS];
   logic [31:0] ref_cur;
   logic [31:0] qry_cur;
   logic [31:0] hit_offset;
   logic [31:0] base_idx;
   logic hit_found;
   logic [7:0] cur_mapq;
   logic cur_rev;
   logic cur_skip;

   rsp_type expected_bins [$];
   rsp_type want;
   int errors = 0;

   logic [63:0] run;
   logic [63:0] ref64;
   logic [63:0] tgt64;
   logic [63:0] limit64;
   logic hit;
   logic known;
   logic [1:0] base_sel;
   logic [7:0] qual;
   int idx;

   function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = {32'd0, a} + b;
      return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg_target = '0;
         cfg_ref_len = 31'h7FFF_FFFF;
         cfg_cap = 1'b0;
         cfg_skip = 1'b0;
         foreach (bin_counts[i]) bin_counts[i] = '0;
         ref_cur = '0;
         qry_cur = '0;
         hit_offset = '0;
         base_idx = '0;
         hit_found = 1'b0;
         cur_mapq = '0;
         cur_rev = 1'b0;
         cur_skip = 1'b1;
         expected_bins.delete();
      end else begin
         if (rsp_strobe === 1'b1) begin
            if (expected_bins.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("checker: result with no readout pending, bin %0d count %0d",
                           rsp_payload.bin_echo, rsp_payload.bin_count);
            end else begin
               want = expected_bins.pop_front();
               if (want.bin_count !== rsp_payload.bin_count ||
                   want.bin_echo !== rsp_payload.bin_echo) begin
                  errors++;
                  if (errors <= MAX_REPORTS)
                     $display("checker: count expected %0d got %0d, echo expected %0d got %0d",
                              want.bin_count, rsp_payload.bin_count,
                              want.bin_echo, rsp_payload.bin_echo);
               end
            end
         end

         if (csr_valid === 1'b1 && csr_ready === 1'b1) begin
            case (csr_index)
               CSR_TARGET_POSITION: cfg_target = csr_data[30:0];
               CSR_REFERENCE_LENGTH: cfg_ref_len = csr_data[30:0];
               CSR_CAP_BY_MAPQ: cfg_cap = csr_data[0];
               CSR_SKIP_DUPLICATES: cfg_skip = csr_data[0];
               default: ;
            endcase
         end

         if (start === 1'b1 && busy === 1'b0) begin
            case (req_payload.mode)
               MODE_HEADER: begin
                  ref_cur = {1'b0, req_payload.read_pos};
                  cur_mapq = req_payload.map_quality;
                  cur_rev = req_payload.reverse_strand;
                  cur_skip = cfg_skip && req_payload.duplicate;
                  qry_cur = '0;
                  hit_offset = '0;
                  hit_found = 1'b0;
                  base_idx = '0;
               end
               MODE_CIGAR: begin
                  if (!cur_skip && !hit_found) begin
                     run = {36'd0, req_payload.cigar_len};
                     case (req_payload.cigar_op)
                        OP_M: begin
                           ref64 = {32'd0, ref_cur};
                           tgt64 = {33'd0, cfg_target};
                           limit64 = {33'd0, cfg_ref_len};
                           if (ref64 + run > limit64)
                              run = (limit64 > ref64) ? limit64 - ref64 : 64'd0;
                           if (ref64 <= tgt64 && tgt64 < ref64 + run) begin
                              hit_offset = sat_sum(qry_cur, tgt64 - ref64);
                              hit_found = 1'b1;
                           end else begin
                              ref_cur = sat_sum(ref_cur, run);
                              qry_cur = sat_sum(qry_cur, run);
                           end
                        end
                        OP_I, OP_S: qry_cur = sat_sum(qry_cur, run);
                        OP_D, OP_N: ref_cur = sat_sum(ref_cur, run);
                        default: ;
                     endcase
                  end
               end
               MODE_BASE: begin
                  hit = !cur_skip && hit_found && base_idx == hit_offset;
                  base_idx = sat_sum(base_idx, 64'd1);
                  known = 1'b1;
                  base_sel = 2'd0;
                  case (req_payload.base_code)
                     BASE_A: base_sel = 2'd0;
                     BASE_C: base_sel = 2'd1;
                     BASE_G: base_sel = 2'd2;
                     BASE_T: base_sel = 2'd3;
                     default: known = 1'b0;
                  endcase
                  qual = req_payload.base_quality;
                  if (cfg_cap && cur_mapq < qual) qual = cur_mapq;
                  if (hit && known && int'(req_payload.base_quality) < QB) begin
                     idx = int'(cur_rev) * 4 * QB + int'(base_sel) * QB + int'(qual);
                     bin_counts[idx] = bin_counts[idx] + 32'd1;
                  end
               end
               default: begin
                  want.bin_echo = req_payload.bin_index;
                  want.bin_count = (int'(req_payload.bin_index) < BINS) ?
                                   bin_counts[req_payload.bin_index] : '0;
                  expected_bins.push_back(want);
               end
            endcase
         end
      end
      readouts_pending <= expected_bins.size();
      mismatch_count <= errors;
   end

endmodule

// ===== tb/cigar_point_base_quality_histogram_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the CIGAR point base quality histogram unit: clock, reset,
// directed and random read streams, register phases, watchdog and verdict.
// Depends on cpbq_pkg, the unit itself and cpbq_histogram_checker.
module cigar_point_base_quality_histogram_unit_tb;
   import cpbq_pkg::*;

   localparam int QB = QUAL_BINS_DEFAULT;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 16;
   localparam int PHASES = 8;
   localparam int ITEMS_PER_PHASE = 185;
   localparam logic [3:0] OP_HARD_CLIP = 4'd5;
   localparam logic [3:0] OP_SEQ_MISMATCH = 4'd8;
   localparam logic [3:0] OP_TOP_CODE = 4'd15;
   localparam logic [3:0] BASE_N = 4'd15;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_payload;
   logic rsp_strobe;
   rsp_type rsp_payload;
   logic csr_valid;
   logic csr_ready;
   logic [1:0] csr_index;
   logic [31:0] csr_data;

   int readouts_pending;
   int mismatch_count;
   int stall_count = 0;
   int items_sent = 0;
   int phase_end;
   bit quiet = 1'b0;
   logic [30:0] cur_target;
   logic [7:0] hot_qual [4];

   cigar_point_base_quality_histogram_unit DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_payload(req_payload),
      .rsp_strobe(rsp_strobe),
      .rsp_payload(rsp_payload),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   cpbq_histogram_checker checker_inst (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_payload(req_payload),
      .rsp_strobe(rsp_strobe),
      .rsp_payload(rsp_payload),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .readouts_pending(readouts_pending),
      .mismatch_count(mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || (csr_valid === 1'b1 && csr_ready === 1'b1) ||
          rsp_strobe === 1'b1)
         stall_count <= 0;
      else
         stall_count <= stall_count + 1;
      if (stall_count >= WATCHDOG_LIMIT) begin
         $display("cigar_point_base_quality_histogram_unit_tb: done, errors");
         $finish;
      end
   end

   function automatic req_type filler();
      logic [127:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom};
      return raw[$bits(req_type)-1:0];
   endfunction

   function automatic logic [3:0] pick_op();
      int w;
      w = $urandom_range(0, 9);
      case (w)
         0, 1, 2, 3: return OP_M;
         4: return OP_I;
         5: return OP_S;
         6: return OP_D;
         7: return OP_N;
         8: return OP_HARD_CLIP;
         default: return 4'($urandom_range(5, 15));
      endcase
   endfunction

   function automatic logic [3:0] pick_base();
      int w;
      w = $urandom_range(0, 6);
      case (w)
         0: return BASE_A;
         1: return BASE_C;
         2: return BASE_G;
         3: return BASE_T;
         4: return BASE_A;
         5: return BASE_T;
         default: return 4'($urandom_range(0, 15));
      endcase
   endfunction

   function automatic logic [7:0] pick_qual();
      int w;
      w = $urandom_range(0, 9);
      if (w < 8) return hot_qual[$urandom_range(0, 3)];
      if (w == 8) return 8'($urandom_range(0, QB - 1));
      return 8'($urandom_range(QB, 255));
   endfunction

   task automatic pause_sender(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic send_item(input req_type item);
      start <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (busy !== 1'b0);
      items_sent++;
      if (!quiet && $urandom_range(0, 7) == 0) pause_sender($urandom_range(1, 14));
   endtask

   task automatic send_header(input logic [30:0] pos, input logic [7:0] mapq,
                              input logic rev, input logic dup);
      req_type r;
      r = filler();
      r.mode = MODE_HEADER;
      r.read_pos = pos;
      r.map_quality = mapq;
      r.reverse_strand = rev;
      r.duplicate = dup;
      send_item(r);
   endtask

   task automatic send_op(input logic [3:0] op, input logic [27:0] len);
      req_type r;
      r = filler();
      r.mode = MODE_CIGAR;
      r.cigar_op = op;
      r.cigar_len = len;
      send_item(r);
   endtask

   task automatic send_base(input logic [3:0] code, input logic [7:0] qual);
      req_type r;
      r = filler();
      r.mode = MODE_BASE;
      r.base_code = code;
      r.base_quality = qual;
      send_item(r);
   endtask

   task automatic send_readout(input logic [9:0] bin);
      req_type r;
      r = filler();
      r.mode = MODE_READOUT;
      r.bin_index = bin;
      send_item(r);
   endtask

   task automatic csr_put(input csr_index_type idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
   endtask

   task automatic write_config(input logic [30:0] target, input logic [30:0] ref_len,
                               input logic cap, input logic skip);
      logic [31:0] noise;
      noise = $urandom;
      csr_put(CSR_TARGET_POSITION, {noise[31], target});
      csr_put(CSR_REFERENCE_LENGTH, {noise[30], ref_len});
      csr_put(CSR_CAP_BY_MAPQ, {noise[31:1], cap});
      csr_put(CSR_SKIP_DUPLICATES, {noise[30:0], skip});
      csr_valid <= 1'b0;
      cur_target = target;
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (readouts_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_read();
      int pick;
      int k;
      logic [30:0] pos;
      logic [7:0] mapq;
      logic [9:0] bin;
      pick = $urandom_range(0, 99);
      mapq = ($urandom_range(0, 1) == 0) ? hot_qual[$urandom_range(0, 3)] :
             8'($urandom_range(0, 255));
      if (pick < 15) begin
         repeat ($urandom_range(1, 4)) send_item(filler());
      end else if (pick < 20) begin
         pos = ($urandom_range(0, 1) == 0) ? 31'h7FFF_FFFF - 31'($urandom_range(0, 255)) :
               31'($urandom);
         send_header(pos, mapq, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         if ($urandom_range(0, 1) == 0)
            repeat (10) send_op(($urandom_range(0, 1) == 0) ? OP_D : OP_N,
                                28'hFFF_FFFF - 28'($urandom_range(0, 15)));
         else
            repeat (17) send_op(($urandom_range(0, 1) == 0) ? OP_I : OP_S,
                                28'hFFF_FFFF - 28'($urandom_range(0, 15)));
         send_op(OP_M, 28'($urandom));
         repeat ($urandom_range(0, 4)) send_base(pick_base(), pick_qual());
         send_readout(10'($urandom_range(0, 1023)));
      end else begin
         k = $urandom_range(0, 20);
         pos = (int'(cur_target) > k) ? cur_target - 31'(k) : 31'd0;
         if ($urandom_range(0, 9) == 0) pos = 31'($urandom);
         send_header(pos, mapq, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
         repeat ($urandom_range(0, 5)) send_op(pick_op(), 28'($urandom_range(0, 8)));
         send_op(OP_M, 28'($urandom_range(0, 40)));
         repeat ($urandom_range(0, 30)) send_base(pick_base(), pick_qual());
         repeat ($urandom_range(1, 2)) begin
            if ($urandom_range(0, 4) == 0)
               bin = 10'($urandom_range(0, 1023));
            else
               bin = 10'($urandom_range(0, 1) * 4 * QB + $urandom_range(0, 3) * QB +
                         int'(hot_qual[$urandom_range(0, 3)]));
            send_readout(bin);
         end
      end
      if (!quiet && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 14));
   endtask

   initial begin
      logic [30:0] t;
      logic [30:0] len;
      reset <= 1'b1;
      start <= 1'b0;
      req_payload <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      hot_qual[0] = 8'd0;
      hot_qual[1] = 8'(QB - 1);
      hot_qual[2] = 8'd20;
      hot_qual[3] = 8'd40;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      write_config(31'd100, 31'h7FFF_FFFF, 1'b0, 1'b0);

      send_base(BASE_A, 8'd5);
      send_op(OP_M, 28'd50);
      send_readout(10'd0);
      send_readout(10'd1023);
      send_header(31'd98, 8'd255, 1'b0, 1'b1);
      send_op(OP_S, 28'd1);
      send_op(OP_D, 28'd1);
      send_op(OP_HARD_CLIP, 28'd7);
      send_op(OP_TOP_CODE, 28'hFFF_FFFF);
      send_op(OP_M, 28'd5);
      send_op(OP_I, 28'd3);
      send_base(BASE_C, 8'd20);
      send_base(BASE_G, 8'd20);
      send_base(BASE_T, 8'(QB - 1));
      send_base(BASE_A, 8'd30);
      send_readout(10'(3 * QB + QB - 1));
      send_header(31'd100, 8'd0, 1'b1, 1'b0);
      send_op(OP_SEQ_MISMATCH, 28'd4);
      send_op(OP_M, 28'd1);
      send_base(BASE_N, 8'd40);
      send_header(31'd100, 8'd60, 1'b1, 1'b0);
      send_op(OP_M, 28'd1);
      send_base(BASE_A, 8'(QB));
      send_readout(10'(4 * QB));
      drain_results();

      phase_end = items_sent;
      for (int phase = 1; phase <= PHASES; phase++) begin
         t = 31'($urandom_range(0, 100000));
         case (phase)
            1: write_config(t, 31'h7FFF_FFFF, 1'b0, 1'b0);
            2: write_config(31'd0, 31'h7FFF_FFFF, 1'b1, 1'b1);
            3: write_config(31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0, 1'b1);
            4: write_config(t, t + 31'($urandom_range(0, 8)), 1'b1, 1'b0);
            5: write_config(t, 31'd0, 1'b0, 1'b0);
            6: begin
               len = 31'($urandom);
               write_config(31'($urandom), len, 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)));
            end
            7: write_config(t + 31'd20, t + 31'($urandom_range(0, 19)), 1'b1, 1'b1);
            default: write_config(t, 31'h7FFF_FFFF, 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)));
         endcase
         hot_qual[2] = 8'($urandom_range(1, QB - 2));
         hot_qual[3] = 8'($urandom_range(1, QB - 2));
         quiet = (phase == 3) || (phase == PHASES);
         phase_end += ITEMS_PER_PHASE;
         while (items_sent < phase_end) send_read();
         drain_results();
      end

      if (mismatch_count == 0)
         $display("cigar_point_base_quality_histogram_unit_tb: done, clean");
      else
         $display("cigar_point_base_quality_histogram_unit_tb: done, errors");
      $finish;
   end

endmodule

// ===== cigar_point_base_quality_histogram_unit.f =====
hdl/cpbq_pkg.sv
hdl/cpbq_front.sv
hdl/cpbq_queue.sv
hdl/cpbq_back.sv
hdl/cigar_point_base_quality_histogram_unit.sv
tb/cpbq_histogram_checker.sv
tb/cigar_point_base_quality_histogram_unit_tb.sv
